/* hdl/fbcd_pkg.sv */
`default_nettype none
package fbcd_pkg;
	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_RECLAIM = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		KIND_ANSWER    = 1'b0,
		KIND_WRITEBACK = 1'b1
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch request
		logic scan_clr;    // reset scan pointer and hit/free search
		logic scan_step;   // examine one slot
		logic cold_clr;    // reset cold-list pass
		logic cold_step;   // examine one slot for the cold list
		logic wb_load;     // read evicted slot (issue RAM read)
		logic wb_emit;     // load output with a writeback
		logic wb_release;  // release the evicted slot
		logic ans_update;  // perform the request's state update
		logic ans_emit;    // load output with the answer
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic cold_done;
		logic hit;
		logic any_free;
		logic is_write;
		logic wb_last;
	} stat_t;
endpackage
`default_nettype wire

/* hdl/fbcd_ram.sv */
`default_nettype none
module fbcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hdl/fbcd_ctrl.sv */
`default_nettype none
module fbcd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_busy,
	output logic               in_rdy,
	output fbcd_pkg::ctrl_t    ctrl,
	input  wire fbcd_pkg::stat_t stat
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SCAN  = 8'b0000_0010,
		ST_COLD  = 8'b0000_0100,
		ST_WBRD  = 8'b0000_1000,
		ST_WBWT  = 8'b0001_0000,
		ST_WBOUT = 8'b0010_0000,
		ST_UPD   = 8'b0100_0000,
		ST_ANS   = 8'b1000_0000
	} state_t;

	state_t state_q;

	assign in_rdy = (state_q == ST_IDLE);

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.load     = in_fire;
				ctrl.scan_clr = in_fire;
			end
			ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				ctrl.cold_clr  = stat.scan_done;
			end
			ST_COLD:  ctrl.cold_step = 1'b1;
			ST_WBRD:  ctrl.wb_load = 1'b1;
			ST_WBWT:  ;
			ST_WBOUT: begin
				ctrl.wb_emit    = !out_busy;
				ctrl.wb_release = !out_busy;
			end
			ST_UPD:   ctrl.ans_update = 1'b1;
			ST_ANS:   ctrl.ans_emit = !out_busy;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_SCAN;
				ST_SCAN: if (stat.scan_done) begin
					if (stat.is_write && !stat.hit && !stat.any_free)
						state_q <= ST_COLD;
					else
						state_q <= ST_UPD;
				end
				ST_COLD:  if (stat.cold_done) state_q <= ST_WBRD;
				ST_WBRD:  state_q <= ST_WBWT;
				ST_WBWT:  state_q <= ST_WBOUT;
				ST_WBOUT: if (!out_busy) state_q <= stat.wb_last ? ST_UPD : ST_WBRD;
				ST_UPD:   state_q <= ST_ANS;
				ST_ANS:   if (!out_busy) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/fbcd_dp.sv */
`default_nettype none
module fbcd_dp #(
	parameter int SLOTS      = 64,
	parameter int EVICT      = 4,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                favor_metadata,
	input  wire logic [1:0]          opcode,
	input  wire logic [31:0]         block_number,
	input  wire logic                is_metadata,
	input  wire fbcd_pkg::ctrl_t     ctrl,
	output fbcd_pkg::stat_t          stat,
	output logic [39:0]              res_q,  // kind, hit, slot, evicted_block
	output logic                     res_last_q
);
	localparam int SW = $clog2(SLOTS);
	localparam int EW = (EVICT > 1) ? $clog2(EVICT) : 1;
	localparam int TW = COUNT_BITS + 1;
	localparam int CW = 2 * COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	// per-slot flags in flip-flops; at reset valid_q is cleared and free_q set
	logic [SLOTS-1:0] valid_q, free_q;

	logic [1:0]        op_q;
	logic [31:0]       blk_q;
	logic              two_q;
	logic [SW:0]       ptr_q;
	logic              hit_q, free_found_q;
	logic [SW-1:0]     hs_q, fs_q;
	logic [SW-1:0]     cold_q [EVICT];
	logic [TW-1:0]     cold_tot_q [EVICT];
	logic [EW-1:0]     wi_q;
	logic [SW-1:0]     wslot_q;

	// tag store
	logic              tag_we;
	logic [SW-1:0]     tag_waddr, tag_raddr;
	logic [31:0]       tag_rdata;

	fbcd_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(blk_q),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	// count store, {read_count, write_count} per slot; only the counts of valid
	// slots are ever used, and a slot is written in full when it is taken
	logic              cnt_we;
	logic [SW-1:0]     cnt_waddr, cnt_raddr;
	logic [CW-1:0]     cnt_wdata, cnt_rdata;

	fbcd_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	logic [SW-1:0] cur;
	assign cur = ptr_q[SW-1:0];

	// the scan reads one tag ahead; ptr_q names the slot whose tag is on rdata
	logic [SW:0] ptr_nx;
	assign ptr_nx = ptr_q + 1'b1;
	always_comb begin
		if (ctrl.scan_clr)
			tag_raddr = '0;
		else if (ctrl.wb_load)
			tag_raddr = cold_q[wi_q];
		else if (ctrl.scan_step)
			tag_raddr = ptr_nx[SW-1:0];
		else
			tag_raddr = wslot_q;
	end
	assign tag_we    = ctrl.ans_update && (op_q == fbcd_pkg::OP_WRITE) && !hit_q;
	assign tag_waddr = fs_q;

	// counts: the hit slot is read during the scan for the update; with no hit
	// slot 0 is read so the cold pass starts on the next cycle
	always_comb begin
		if (ctrl.scan_step)
			cnt_raddr = stat.hit ? (hit_q ? hs_q : cur) : '0;
		else if (ctrl.cold_step)
			cnt_raddr = ptr_nx[SW-1:0];
		else
			cnt_raddr = '0;
	end

	logic [COUNT_BITS-1:0] cnt_w, cnt_r;
	logic [TW-1:0]         cnt_tot;
	assign cnt_w   = cnt_rdata[COUNT_BITS-1:0];
	assign cnt_r   = cnt_rdata[CW-1:COUNT_BITS];
	assign cnt_tot = {1'b0, cnt_w} + {1'b0, cnt_r};

	// cold-list worst member: total of each member, pick first maximum
	logic [TW-1:0] best;
	logic [EW-1:0] bpos;
	always_comb begin
		best = '0;
		bpos = '0;
		for (int i = 0; i < EVICT; i++) begin
			if (i == 0 || cold_tot_q[i] > best) begin
				best = cold_tot_q[i];
				bpos = EW'(i);
			end
		end
	end

	logic [COUNT_BITS-1:0] inc;
	assign inc = two_q ? COUNT_BITS'(2) : COUNT_BITS'(1);

	function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] v,
			input logic [COUNT_BITS-1:0] a);
		logic [COUNT_BITS:0] s;
		s = {1'b0, v} + {1'b0, a};
		return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
	endfunction

	assign cnt_we    = ctrl.ans_update &&
		((op_q == fbcd_pkg::OP_WRITE) || (op_q == fbcd_pkg::OP_READ && hit_q));
	assign cnt_waddr = hit_q ? hs_q : fs_q;
	always_comb begin
		if (op_q == fbcd_pkg::OP_READ)
			cnt_wdata = {sat(cnt_r, inc), cnt_w};
		else if (hit_q)
			cnt_wdata = {cnt_r, sat(cnt_w, inc)};
		else
			cnt_wdata = {{COUNT_BITS{1'b0}}, sat('0, inc)};
	end

	assign stat.scan_done = (ptr_q == (SW+1)'(SLOTS - 1));
	assign stat.cold_done = (ptr_q == (SW+1)'(SLOTS - 1));
	assign stat.hit       = hit_q || (valid_q[cur] && tag_rdata == blk_q);
	assign stat.any_free  = free_found_q || free_q[cur];
	assign stat.is_write  = (op_q == fbcd_pkg::OP_WRITE);
	assign stat.wb_last   = (wi_q == EW'(EVICT - 1));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q  <= opcode;
			blk_q <= block_number;
			two_q <= favor_metadata && is_metadata;
		end
		if (ctrl.wb_load)
			wslot_q <= cold_q[wi_q];
		if (ctrl.wb_emit) begin
			res_q      <= {fbcd_pkg::KIND_WRITEBACK, 1'b0, 6'(wslot_q), tag_rdata};
			res_last_q <= 1'b0;
		end else if (ctrl.ans_emit) begin
			res_q <= {fbcd_pkg::KIND_ANSWER, hit_q && (op_q != fbcd_pkg::OP_NONE),
				(op_q == fbcd_pkg::OP_WRITE) ? 6'(hit_q ? hs_q : fs_q) :
				(hit_q && op_q != fbcd_pkg::OP_NONE) ? 6'(hs_q) : 6'd0, 32'd0};
			res_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			free_q       <= '1;
			ptr_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			hs_q         <= '0;
			fs_q         <= '0;
			wi_q         <= '0;
			for (int i = 0; i < EVICT; i++) begin
				cold_q[i]     <= '0;
				cold_tot_q[i] <= '0;
			end
		end else begin
			if (ctrl.scan_clr || ctrl.cold_clr)
				ptr_q <= '0;
			else if (ctrl.scan_step || ctrl.cold_step)
				ptr_q <= ptr_nx;
			if (ctrl.scan_clr) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				hs_q         <= '0;
				fs_q         <= '0;
			end else if (ctrl.scan_step) begin
				if (!hit_q && valid_q[cur] && tag_rdata == blk_q) begin
					hit_q <= 1'b1;
					hs_q  <= cur;
				end
				if (!free_found_q && free_q[cur]) begin
					free_found_q <= 1'b1;
					fs_q         <= cur;
				end
			end
			if (ctrl.cold_clr)
				wi_q <= '0;
			// first EVICT slots seed the list, later ones may replace the worst
			if (ctrl.cold_step) begin
				if (ptr_q < (SW+1)'(EVICT)) begin
					cold_q[ptr_q[EW-1:0]]     <= cur;
					cold_tot_q[ptr_q[EW-1:0]] <= cnt_tot;
				end else if ({1'b0, cnt_w} < best) begin
					cold_q[bpos]     <= cur;
					cold_tot_q[bpos] <= cnt_tot;
				end
			end
			if (ctrl.wb_release) begin
				valid_q[wslot_q] <= 1'b0;
				free_q[wslot_q]  <= 1'b1;
				wi_q             <= wi_q + 1'b1;
				// the lowest slot freed by eviction becomes the lowest free slot
				if (!free_found_q || wslot_q < fs_q) begin
					free_found_q <= 1'b1;
					fs_q         <= wslot_q;
				end
			end
			if (ctrl.ans_update) begin
				case (op_q)
					fbcd_pkg::OP_WRITE:
						if (!hit_q) begin
							free_q[fs_q]  <= 1'b0;
							valid_q[fs_q] <= 1'b1;
						end
					fbcd_pkg::OP_RECLAIM:
						if (hit_q) begin
							valid_q[hs_q] <= 1'b0;
							free_q[hs_q]  <= 1'b1;
						end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/frequency_buffer_cache_directory.sv */
`default_nettype none
// Directory for a block buffer cache with SLOTS slots and frequency-based
// replacement.
// s_axis: one request a beat. tdata = opcode[1:0], block_number[33:2];
//   tuser = is_metadata. s_axis_tready is high only while the block is idle.
// m_axis: result beats. tdata = hit[0], slot[6:1], evicted_block[38:7];
//   tuser = result_kind; tlast marks the answer, the final beat of a request.
// favor_wr/favor_data write the favour-metadata register; write it while idle only (not enforced).
// The serial tag scan reads one tag a cycle, then the state update is done
// and the answer is registered. A write miss with no free slot adds a
// cold-list pass over all slots and EVICT writeback beats before the update.
// One request is in flight at a time.
// A stalled receiver holds the current output beat; the block waits.
// Reset: all slots invalid and free, favouring off; no clearing pass (tags
// and counts are used only for valid slots).
module frequency_buffer_cache_directory #(
	parameter int SLOTS      = 64,
	parameter int EVICT      = 4,
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // opcode, block_number
	input  wire logic        s_axis_tuser,  // is_metadata
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // hit, slot, evicted_block
	output logic             m_axis_tuser,  // result_kind
	output logic             m_axis_tlast,
	input  wire logic        favor_wr,
	input  wire logic        favor_data
);
	fbcd_pkg::ctrl_t ctrl;
	fbcd_pkg::stat_t stat;
	logic favor_q, in_fire, out_busy;
	logic [39:0] res;
	logic        res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			favor_q <= 1'b0;
		else if (favor_wr)
			favor_q <= favor_data;
	end

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_busy = m_axis_tvalid && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (ctrl.wb_emit || ctrl.ans_emit)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	fbcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_busy),
		.in_rdy(s_axis_tready), .ctrl(ctrl), .stat(stat)
	);

	fbcd_dp #(.SLOTS(SLOTS), .EVICT(EVICT), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .favor_metadata(favor_q),
		.opcode(s_axis_tdata[1:0]), .block_number(s_axis_tdata[33:2]),
		.is_metadata(s_axis_tuser), .ctrl(ctrl), .stat(stat),
		.res_q(res), .res_last_q(res_last)
	);

	assign m_axis_tdata = {1'b0, res[31:0], res[37:32], res[38]};
	assign m_axis_tuser = res[39];
	assign m_axis_tlast = res_last;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy |=> $stable(m_axis_tdata)) else $error("beat changed while stalled");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wb_emit && ctrl.ans_emit)) else $error("two emits at once");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !(ctrl.wb_emit || ctrl.ans_emit)) else $error("emit while idle");
endmodule
`default_nettype wire
